@@ sv/sample_gain_fade_peak_defines.svh @@
// Assertion macros shared by the sample gain, fade and peak block.
`ifndef SAMPLE_GAIN_FADE_PEAK_DEFINES_SVH
`define SAMPLE_GAIN_FADE_PEAK_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SGFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SGFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/sgfp_pkg.sv @@
// Types, constants and codes for the sample gain, fade and peak block.
package sgfp_pkg;

    // Field and datapath widths
    localparam int SAMPLE_W = 16;
    localparam int LEN_W    = 25;
    localparam int POS_W    = 24;
    localparam int GAIN_W   = 16;
    localparam int MPLIER_W = 17;              // magnitude of a 16-bit sample
    localparam int MCAND_W  = LEN_W;
    localparam int PROD_W   = MCAND_W + MPLIER_W;
    localparam int Q_SHIFT  = 10;              // fade factor in 1/1024 steps
    localparam int QF_W     = Q_SHIFT + 1;     // factor is at most 1024
    localparam int DVD_W    = LEN_W + Q_SHIFT; // widest dividend
    localparam int CNT_W    = $clog2(DVD_W + 1);
    localparam int IDX_W    = 2;

    // Constants
    localparam logic [LEN_W-1:0]  LEN_CAP   = LEN_W'(1 << 24);
    localparam logic [LEN_W-1:0]  NORM_DIV  = LEN_W'(100);
    localparam logic [GAIN_W-1:0] GAIN_RST  = GAIN_W'(100);
    localparam logic [DVD_W-1:0]  WIDE_POS  = DVD_W'(32767);
    localparam logic [DVD_W-1:0]  WIDE_NEG  = DVD_W'(32768);
    localparam logic [DVD_W-1:0]  NARR_POS  = DVD_W'(127);
    localparam logic [DVD_W-1:0]  NARR_NEG  = DVD_W'(128);

    // Mode codes
    localparam logic [1:0] MODE_NORM     = 2'd0;
    localparam logic [1:0] MODE_FADE_IN  = 2'd1;
    localparam logic [1:0] MODE_FADE_OUT = 2'd2;
    localparam logic [1:0] MODE_PASS     = 2'd3;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_MODE = 2'd0;
    localparam logic [IDX_W-1:0] REG_WIDE = 2'd1;
    localparam logic [IDX_W-1:0] REG_GAIN = 2'd2;
    localparam logic [IDX_W-1:0] REG_FLEN = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       last_in;
    } sgfp_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic [SAMPLE_W-1:0]        peak_level;
        logic                       last_out;
    } sgfp_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_MUL_Q,
        ST_DONE
    } sgfp_state_t;

endpackage

@@ sv/sgfp_mul.sv @@
// Serial shift-add multiplier, one multiplier bit per cycle.
module sgfp_mul import sgfp_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [MCAND_W-1:0]  mcand,
    input  logic [MPLIER_W-1:0] mplier,
    output logic [PROD_W-1:0]   prod,
    output logic                done
);

    logic [PROD_W-1:0]   acc_reg, acc_next;
    logic [PROD_W-1:0]   mcand_reg, mcand_next;
    logic [MPLIER_W-1:0] mplier_reg, mplier_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    // Add the shifted multiplicand when the low multiplier bit is set
    always_comb begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start) begin
            acc_next    = '0;
            mcand_next  = PROD_W'(mcand);
            mplier_next = mplier;
            busy_next   = 1'b1;
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            if (mplier_next == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;

endmodule

@@ sv/sgfp_div.sv @@
// Serial restoring divider, one quotient bit per cycle.
module sgfp_div import sgfp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DVD_W-1:0]  dividend,
    input  logic [LEN_W-1:0]  divisor,
    output logic [DVD_W-1:0]  quotient,
    output logic              done
);

    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [LEN_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [LEN_W:0]   trial;
    logic             qbit;

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        cnt_reg <= cnt_next;
    end

    // Shift in the next dividend bit, subtract when it fits
    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DVD_W-1]};
        qbit      = (trial >= {1'b0, dsr_reg});
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (qbit) begin
                rem_next = LEN_W'(trial - {1'b0, dsr_reg});
            end else begin
                rem_next = trial[LEN_W-1:0];
            end
            quo_next = {quo_reg[DVD_W-2:0], qbit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

@@ sv/sample_gain_fade_peak.sv @@
// Top level: per-sample gain, linear fade and peak meter.
//
// Input words arrive on s_valid/s_ready/s_data (sample_in, last_in) and
// each one yields exactly one result word on m_valid/m_ready/m_data
// (sample_out, peak_level, last_out). Registers are written through
// cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always high and
// writes belong between items.
// One item is worked at a time. Normalize and 8-bit fades run a serial
// multiply, one sample magnitude bit per step until the remaining bits
// are zero, then the 35-step serial divide. 16-bit fades divide first
// for the 1/1024 factor, then multiply. The next word is taken in the
// cycle after the result is loaded.
// Reset (synchronous, active low) restores mode normalize, 16-bit samples,
// gain 100 percent, fade length 1, and clears position and peak.
// The result sits in an output register; a new input word is taken while it
// waits. When the receiver stalls and a second result is finished, the
// block holds it until the output register frees up.
`include "sample_gain_fade_peak_defines.svh"

module sample_gain_fade_peak import sgfp_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  sgfp_in_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output sgfp_out_t        m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0] cfg_data
);

    // Configuration
    logic [1:0]        mode_reg;
    logic              wide_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [LEN_W-1:0]  flen_reg;

    // Region state
    logic [POS_W-1:0]    pos_reg;
    logic [SAMPLE_W-1:0] peak_reg;

    // Captured item
    logic signed [SAMPLE_W-1:0] s_reg;
    logic [MPLIER_W-1:0]        abs_reg;
    logic                       neg_reg;
    logic [LEN_W-1:0]           num_reg;
    logic                       last_reg;
    logic [SAMPLE_W-1:0]        opeak_reg;

    // Sequencer
    sgfp_state_t      state_reg, state_next;
    logic             mul_go_reg, mul_go_next;
    logic             div_go_reg, div_go_next;
    logic [DVD_W-1:0] mag_reg, mag_next;
    logic             out_load;

    // Output register
    logic      m_valid_reg;
    sgfp_out_t m_data_reg;

    // Units
    logic [MCAND_W-1:0] mul_mcand;
    logic [PROD_W-1:0]  mul_prod;
    logic               mul_done;
    logic [DVD_W-1:0]   div_dividend;
    logic [LEN_W-1:0]   div_divisor;
    logic [DVD_W-1:0]   div_quo;
    logic               div_done;

    // Accept-time values
    logic                       accept;
    logic                       fade_mode;
    logic signed [SAMPLE_W-1:0] s_val;
    logic                       s_neg;
    logic [MPLIER_W-1:0]        s_abs;
    logic [LEN_W-1:0]           len;
    logic [LEN_W-1:0]           len_m1;
    logic [LEN_W-1:0]           pos_i;
    logic [LEN_W-1:0]           num;
    logic [LEN_W-1:0]           pos_adv;
    logic [SAMPLE_W-1:0]        peak_new;
    logic signed [SAMPLE_W-1:0] result;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign fade_mode = (mode_reg == MODE_FADE_IN) || (mode_reg == MODE_FADE_OUT);

    // Sample decode, fade length clamp and region position
    always_comb begin
        if (wide_reg) begin
            s_val = s_data.sample_in;
        end else begin
            s_val = {{8{s_data.sample_in[7]}}, s_data.sample_in[7:0]};
        end
        s_neg = s_val[SAMPLE_W-1];
        if (s_neg) begin
            s_abs = MPLIER_W'(0) - {s_val[SAMPLE_W-1], s_val};
        end else begin
            s_abs = {1'b0, s_val};
        end
        if (flen_reg == '0) begin
            len = LEN_W'(1);
        end else if (flen_reg > LEN_CAP) begin
            len = LEN_CAP;
        end else begin
            len = flen_reg;
        end
        len_m1 = len - 1'b1;
        pos_i  = ({1'b0, pos_reg} > len_m1) ? len_m1 : {1'b0, pos_reg};
        num    = (mode_reg == MODE_FADE_IN) ? pos_i : len - pos_i;
        if (pos_i < len_m1) begin
            pos_adv = pos_i + 1'b1;
        end else begin
            pos_adv = len_m1;
        end
        peak_new = (s_abs[SAMPLE_W-1:0] > peak_reg) ? s_abs[SAMPLE_W-1:0] : peak_reg;
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NORM;
            wide_reg <= 1'b1;
            gain_reg <= GAIN_RST;
            flen_reg <= LEN_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_MODE: mode_reg <= cfg_data[1:0];
                REG_WIDE: wide_reg <= cfg_data[0];
                REG_GAIN: gain_reg <= cfg_data[GAIN_W-1:0];
                REG_FLEN: flen_reg <= cfg_data;
                default:  mode_reg <= mode_reg;
            endcase
        end
    end

    // Region position and running peak
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            peak_reg <= '0;
        end else if (accept) begin
            if (s_data.last_in) begin
                pos_reg  <= '0;
                peak_reg <= '0;
            end else begin
                pos_reg  <= pos_adv[POS_W-1:0];
                peak_reg <= peak_new;
            end
        end
    end

    // Item capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            s_reg     <= s_val;
            abs_reg   <= s_abs;
            neg_reg   <= s_neg;
            num_reg   <= num;
            last_reg  <= s_data.last_in;
            opeak_reg <= peak_new;
        end
    end

    // Unit operand selection
    always_comb begin
        if (state_reg == ST_MUL_Q) begin
            mul_mcand = MCAND_W'(div_quo[QF_W-1:0]);
        end else if (mode_reg == MODE_NORM) begin
            mul_mcand = MCAND_W'(gain_reg);
        end else begin
            mul_mcand = num_reg;
        end
        if (fade_mode && wide_reg) begin
            div_dividend = {num_reg, {Q_SHIFT{1'b0}}};
        end else begin
            div_dividend = mul_prod[DVD_W-1:0];
        end
        div_divisor = (mode_reg == MODE_NORM) ? NORM_DIV : len;
    end

    sgfp_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_go_reg),
        .mcand   (mul_mcand),
        .mplier  (abs_reg),
        .prod    (mul_prod),
        .done    (mul_done)
    );

    sgfp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_go_reg),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .done     (div_done)
    );

    // Sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mul_go_reg <= 1'b0;
            div_go_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mul_go_reg <= mul_go_next;
            div_go_reg <= div_go_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg <= mag_next;
    end

    // Sequencer next state
    always_comb begin
        state_next  = state_reg;
        mul_go_next = 1'b0;
        div_go_next = 1'b0;
        mag_next    = mag_reg;
        out_load    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (mode_reg == MODE_PASS) begin
                        state_next = ST_DONE;
                    end else if (fade_mode && wide_reg) begin
                        div_go_next = 1'b1;
                        state_next  = ST_DIV;
                    end else begin
                        mul_go_next = 1'b1;
                        state_next  = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    div_go_next = 1'b1;
                    state_next  = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    if (fade_mode && wide_reg) begin
                        mul_go_next = 1'b1;
                        state_next  = ST_MUL_Q;
                    end else begin
                        mag_next   = div_quo;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MUL_Q: begin
                if (mul_done) begin
                    mag_next   = DVD_W'(mul_prod[PROD_W-1:Q_SHIFT]);
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sign and clamp to the sample range; pass-through keeps the captured sample
    always_comb begin
        if (mode_reg == MODE_PASS) begin
            result = s_reg;
        end else if (neg_reg) begin
            if (mag_reg >= (wide_reg ? WIDE_NEG : NARR_NEG)) begin
                result = wide_reg ? SAMPLE_W'(-32768) : SAMPLE_W'(-128);
            end else begin
                result = SAMPLE_W'(0) - mag_reg[SAMPLE_W-1:0];
            end
        end else begin
            if (mag_reg > (wide_reg ? WIDE_POS : NARR_POS)) begin
                result = wide_reg ? SAMPLE_W'(32767) : SAMPLE_W'(127);
            end else begin
                result = mag_reg[SAMPLE_W-1:0];
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.sample_out <= result;
            m_data_reg.peak_level <= opeak_reg;
            m_data_reg.last_out   <= last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Checks
    `SGFP_ASSERT_NOW(a_mul_done_state, mul_done,
        (state_reg == ST_MUL) || (state_reg == ST_MUL_Q), "multiply finished out of sequence")
    `SGFP_ASSERT_NOW(a_div_done_state, div_done,
        state_reg == ST_DIV, "divide finished out of sequence")
    `SGFP_ASSERT_NEXT(a_region_clear, accept && s_data.last_in,
        (pos_reg == '0) && (peak_reg == '0), "region state not cleared after last word")
    `SGFP_ASSERT_NOW(a_load_free, out_load,
        !m_valid_reg || m_ready, "result loaded over a pending word")

endmodule

@@ tb/sample_gain_fade_peak_tb.sv @@
// Testbench for sample_gain_fade_peak: directed and random sample words checked against a bench model.
`timescale 1ns / 100ps

module sample_gain_fade_peak_tb;
    import sgfp_pkg::*;

    localparam int     CYCLE_LIMIT   = 600000;
    localparam int     HOLD_CYCLES   = 400;
    localparam int     SETTLE_CYCLES = 120;
    localparam int     PHASES        = 24;
    localparam int     PHASE_WORDS   = 36;
    localparam int     HOLD_WORDS    = 40;
    localparam int     IDLE_PCT      = 12;
    localparam int     MAX_REPORTS   = 40;
    localparam longint PERCENT       = 100;
    localparam longint Q_ONE         = 1024;

    logic             aclk;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    sgfp_in_t         s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    sgfp_out_t        m_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [LEN_W-1:0] cfg_data  = '0;

    // Shadow registers and region state of the bench model
    logic [1:0]          mode_q      = MODE_NORM;
    logic                wide_q      = 1'b1;
    logic [GAIN_W-1:0]   gain_q      = GAIN_RST;
    logic [LEN_W-1:0]    flen_q      = LEN_W'(1);
    logic [POS_W-1:0]    region_pos  = '0;
    logic [SAMPLE_W-1:0] region_peak = '0;

    sgfp_out_t processed_due[$];
    int        err_count   = 0;
    int        cycle_count = 0;
    logic      quiet       = 1'b0;   // no idling on either side
    int        hold_tag    = 0;      // bumped to request a long receiver hold
    int        hold_seen   = 0;
    int        hold_left   = 0;

    sample_gain_fade_peak i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Gain, fade and peak for one sample word; advances the region state
    function automatic sgfp_out_t process_sample(sgfp_in_t w);
        longint    s, lo, hi, len, idx, num, r, mag;
        sgfp_out_t res;
        if (wide_q) begin
            s  = longint'($signed(w.sample_in));
            lo = -32768;
            hi = 32767;
        end else begin
            // 8-bit mode reads only the low byte, wrapping
            s  = longint'($signed(w.sample_in[7:0]));
            lo = -128;
            hi = 127;
        end
        len = longint'(flen_q);
        if (len < 1) len = 1;
        if (len > longint'(LEN_CAP)) len = longint'(LEN_CAP);
        // position past the end (length shrunk) is pulled back to len-1
        idx = longint'(region_pos);
        if (idx > len - 1) idx = len - 1;
        case (mode_q)
            MODE_NORM: begin
                r = (longint'(gain_q) * s) / PERCENT;
            end
            MODE_FADE_IN, MODE_FADE_OUT: begin
                num = (mode_q == MODE_FADE_IN) ? idx : len - idx;
                if (wide_q) r = (((num * Q_ONE) / len) * s) / Q_ONE;
                else r = (num * s) / len;
            end
            default: begin
                r = s;
            end
        endcase
        if (r < lo) r = lo;
        if (r > hi) r = hi;
        // peak meter follows the input, not the processed value
        mag = (s < 0) ? -s : s;
        if (mag > longint'(region_peak)) region_peak = SAMPLE_W'(mag);
        res.sample_out = SAMPLE_W'(r);
        res.peak_level = region_peak;
        res.last_out   = w.last_in;
        if (w.last_in) begin
            region_pos  = '0;
            region_peak = '0;
        end else if (idx < len - 1) begin
            region_pos = POS_W'(idx + 1);
        end else begin
            region_pos = POS_W'(len - 1);
        end
        return res;
    endfunction

    // Track register writes, predict accepted words, check returned words
    always @(posedge aclk) begin : watch_ports
        sgfp_out_t want;
        if (!aresetn) begin
            mode_q      = MODE_NORM;
            wide_q      = 1'b1;
            gain_q      = GAIN_RST;
            flen_q      = LEN_W'(1);
            region_pos  = '0;
            region_peak = '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MODE: mode_q = cfg_data[1:0];
                    REG_WIDE: wide_q = cfg_data[0];
                    REG_GAIN: gain_q = cfg_data[GAIN_W-1:0];
                    REG_FLEN: flen_q = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) processed_due.push_back(process_sample(s_data));
            if (m_valid && m_ready) begin
                if (processed_due.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: unexpected word: sample_out %0d peak_level %0d last_out %0b",
                                 $time, m_data.sample_out, m_data.peak_level, m_data.last_out);
                end else begin
                    want = processed_due.pop_front();
                    if (m_data.sample_out !== want.sample_out ||
                        m_data.peak_level !== want.peak_level ||
                        m_data.last_out !== want.last_out) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS)
                            $display({"%0t: mismatch: sample_out exp %0d got %0d, ",
                                      "peak_level exp %0d got %0d, last_out exp %0b got %0b"},
                                     $time, want.sample_out, m_data.sample_out,
                                     want.peak_level, m_data.peak_level,
                                     want.last_out, m_data.last_out);
                    end
                end
            end
        end
    end

    // Receiver: random stalls, long holds on request
    always @(posedge aclk) begin
        if (hold_tag != hold_seen) begin
            hold_seen <= hold_tag;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offer one word and hold it until taken; sometimes pause afterwards
    task automatic send_word(logic signed [SAMPLE_W-1:0] sample, logic last);
        s_data  <= '{sample_in: sample, last_in: last};
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (!quiet && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(80, 1)) @(posedge aclk);
        end
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [LEN_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Stop sending and wait for every predicted word to come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (processed_due.size() != 0);
        @(posedge aclk);
    endtask

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return {8'($urandom), 8'h7F};
            3: return {8'($urandom), 8'h80};
            4: return SAMPLE_W'($urandom_range(6)) - SAMPLE_W'(3);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Rewrite a random subset of the registers, extremes included
    task automatic random_config();
        logic [LEN_W-1:0] len;
        if ($urandom_range(3) != 0) write_reg(REG_MODE, LEN_W'($urandom_range(3)));
        if ($urandom_range(3) != 0) write_reg(REG_WIDE, LEN_W'($urandom_range(1)));
        if ($urandom_range(3) != 0) begin
            case ($urandom_range(4))
                0: write_reg(REG_GAIN, '0);
                1: write_reg(REG_GAIN, LEN_W'(16'hFFFF));
                default: write_reg(REG_GAIN, LEN_W'($urandom_range(16'hFFFF)));
            endcase
        end
        if ($urandom_range(3) != 0) begin
            case ($urandom_range(9))
                0: len = '0;
                1: len = LEN_W'(1);
                2: len = LEN_CAP;
                3: len = LEN_W'($urandom_range(32'h1FF_FFFF, 32'h100_0001));
                4: len = LEN_W'($urandom);
                default: len = LEN_W'($urandom_range(40, 2));
            endcase
            write_reg(REG_FLEN, len);
        end
    endtask

    // Reset settings: normalize at 100 percent, 16-bit
    task automatic test_reset_defaults();
        send_word(16'sh7FFF, 1'b0);
        send_word(16'sh8000, 1'b0);
        send_word(16'sh0000, 1'b1);
        wait_drained();
    endtask

    // Normalize: full gain clamps both ways, zero gain, 8-bit clamp
    task automatic test_normalize();
        write_reg(REG_MODE, LEN_W'(MODE_NORM));
        write_reg(REG_GAIN, LEN_W'(16'hFFFF));
        send_word(16'sh8000, 1'b0);
        send_word(16'sh0001, 1'b0);
        send_word(16'sh7FFF, 1'b1);
        wait_drained();
        write_reg(REG_GAIN, '0);
        send_word(-16'sd5, 1'b1);
        wait_drained();
        write_reg(REG_WIDE, '0);
        write_reg(REG_GAIN, LEN_W'(250));
        send_word(16'shFF80, 1'b0);
        send_word(16'sh007F, 1'b1);
        wait_drained();
    endtask

    // Fade in past the end of a short region (position saturates), 8-bit fade out
    task automatic test_fades();
        write_reg(REG_WIDE, LEN_W'(1));
        write_reg(REG_MODE, LEN_W'(MODE_FADE_IN));
        write_reg(REG_FLEN, LEN_W'(3));
        repeat (3) send_word(16'sh7FFF, 1'b0);
        send_word(16'sh8000, 1'b1);
        wait_drained();
        write_reg(REG_WIDE, '0);
        write_reg(REG_MODE, LEN_W'(MODE_FADE_OUT));
        send_word(16'sh0080, 1'b0);
        send_word(16'sh0080, 1'b1);
        wait_drained();
    endtask

    // Zero length acts as one, oversize length is capped
    task automatic test_length_limits();
        write_reg(REG_WIDE, LEN_W'(1));
        write_reg(REG_FLEN, '0);
        send_word(16'sh8000, 1'b1);
        wait_drained();
        write_reg(REG_FLEN, '1);
        write_reg(REG_MODE, LEN_W'(MODE_FADE_IN));
        send_word(16'sh7FFF, 1'b1);
        wait_drained();
    endtask

    // Length cut below the current position in mid-region
    task automatic test_length_shrink();
        write_reg(REG_FLEN, LEN_W'(6));
        repeat (4) send_word(16'sh4000, 1'b0);
        wait_drained();
        write_reg(REG_FLEN, LEN_W'(2));
        send_word(16'shC000, 1'b1);
        wait_drained();
    endtask

    // Pass-through in 8-bit mode with junk in the upper byte
    task automatic test_narrow_wrap();
        write_reg(REG_MODE, LEN_W'(MODE_PASS));
        write_reg(REG_WIDE, '0);
        send_word(16'sh7F80, 1'b0);
        send_word(16'sh807F, 1'b1);
        wait_drained();
    endtask

    // Receiver holds off long enough for the block to fill and stall its input
    task automatic test_receiver_hold();
        random_config();
        hold_tag <= hold_tag + 1;
        for (int k = 0; k < HOLD_WORDS; k++) send_word(random_sample(), $urandom_range(15) == 0);
        wait_drained();
    endtask

    // Phases of random settings, each fed mostly whole regions of random words
    task automatic test_random_regions();
        int sent;
        int run_len;
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            random_config();
            quiet <= (phase == PHASES / 2);
            sent = 0;
            while (sent < PHASE_WORDS) begin
                run_len = $urandom_range(48, 1);
                for (int k = 0; k < run_len && sent < PHASE_WORDS; k++) begin
                    // now and then a region ends early
                    send_word(random_sample(), k == run_len - 1 || $urandom_range(99) < 4);
                    sent++;
                end
            end
        end
        wait_drained();
        quiet <= 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_normalize();
        test_fades();
        test_length_limits();
        test_length_shrink();
        test_narrow_wrap();
        test_receiver_hold();
        test_random_regions();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (err_count == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/sgfp_pkg.sv
sv/sgfp_mul.sv
sv/sgfp_div.sv
sv/sample_gain_fade_peak.sv
tb/sample_gain_fade_peak_tb.sv
